### design/tspq_pkg.sv
// Shared types and constants of the three-level stable priority queue.
`default_nettype none

package tspq_pkg;

    // Default configuration
    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 32;
    localparam int NUM_LEVELS   = 3;
    localparam int COUNT_MAX    = 63;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Level codes
    localparam logic [1:0] LVL_NONE = 2'd0;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADLVL = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Request item
    typedef struct packed {
        logic        func;
        logic [1:0]  priority_level;
        logic [7:0]  patient_age;
        logic [31:0] record_tag;
    } t_in;

    // Result item
    typedef struct packed {
        logic        entry_valid;
        logic [1:0]  out_level;
        logic [7:0]  out_age;
        logic [31:0] out_tag;
        logic [1:0]  status_code;
        logic [5:0]  total_count;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the request
        logic exec;   // decide, touch memory, update pointers
        logic done;   // present the result
    } t_ctrl_cmd;

endpackage

`default_nettype wire

### design/tspq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tspq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/tspq_ctrl.sv
// Sequencer of the priority queue: capture, execute, present.
`default_nettype none

module tspq_ctrl
    import tspq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // A new request may come in while the previous result is shown
    assign o_busy = (r_state == S_EXEC);
    assign accept = i_start && !o_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.done = (r_state == S_DONE);

endmodule

`default_nettype wire

### design/tspq_dpath.sv
// Datapath: per-level ring pointers and fill counts, entry memory, result register.
`default_nettype none

module tspq_dpath
    import tspq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl_cmd i_cmd,
    input  wire t_in       i_item,
    output t_out           o_result
);

    localparam int KEEP  = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int WORD  = 8 + KEEP;
    localparam int SLOTS = NUM_LEVELS * DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int PW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = FW + 2;

    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
    localparam logic [AW-1:0] RING_SZ  = AW'(DEPTH);
    localparam logic [CW-1:0] CNT_SAT  = CW'(COUNT_MAX);

    // Captured request
    t_in r_cmd;

    // Ring state per level (index 0 is the lowest level)
    logic [PW-1:0] r_head [NUM_LEVELS];
    logic [PW-1:0] r_tail [NUM_LEVELS];
    logic [FW-1:0] r_fill [NUM_LEVELS];
    logic [FW-1:0] n_fill [NUM_LEVELS];

    // Result register
    logic       r_valid;
    logic [1:0] r_level;
    logic [1:0] r_status;
    logic [5:0] r_count;

    logic            is_ins;
    logic            any_held;
    logic [1:0]      found;
    logic [1:0]      sel;
    logic [FW-1:0]   sel_fill;
    logic [PW-1:0]   sel_ptr;
    logic [PW-1:0]   ptr_next;
    logic            do_write;
    logic            do_read;
    logic [AW-1:0]   addr;
    logic [1:0]      status;
    logic [CW-1:0]   sum;
    logic [5:0]      count;
    logic [WORD-1:0] wdata;
    logic [WORD-1:0] rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_item;
        end
    end

    // Highest non-empty level
    always_comb begin
        any_held = 1'b1;
        priority if (r_fill[2] != '0) found = 2'd2;
        else if     (r_fill[1] != '0) found = 2'd1;
        else if     (r_fill[0] != '0) found = 2'd0;
        else begin
            found    = 2'd0;
            any_held = 1'b0;
        end
    end

    // Ring selection: insert level or the found level
    assign is_ins   = (r_cmd.func == FUNC_INSERT);
    assign sel      = is_ins ? (r_cmd.priority_level - 2'd1) : found;
    always_comb begin
        unique case (sel)
            2'd0:    begin sel_fill = r_fill[0]; sel_ptr = is_ins ? r_tail[0] : r_head[0]; end
            2'd1:    begin sel_fill = r_fill[1]; sel_ptr = is_ins ? r_tail[1] : r_head[1]; end
            2'd2:    begin sel_fill = r_fill[2]; sel_ptr = is_ins ? r_tail[2] : r_head[2]; end
            default: begin sel_fill = '0;        sel_ptr = '0;                             end
        endcase
    end
    assign ptr_next = (sel_ptr == PTR_LAST) ? '0 : sel_ptr + PW'(1);

    // Outcome of the operation
    always_comb begin
        do_write = 1'b0;
        do_read  = 1'b0;
        status   = ST_OK;
        if (is_ins) begin
            if (r_cmd.priority_level == LVL_NONE) begin
                status = ST_BADLVL;
            end else if (sel_fill == FILL_MAX) begin
                status = ST_FULL;
            end else begin
                do_write = i_cmd.exec;
            end
        end else begin
            if (any_held) begin
                do_read = i_cmd.exec;
            end else begin
                status = ST_EMPTY;
            end
        end
    end

    assign addr  = (AW'(sel) * RING_SZ) + AW'(sel_ptr);
    assign wdata = {r_cmd.patient_age, KEEP'(r_cmd.record_tag)};

    // Fill counts after this operation
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            n_fill[i] = r_fill[i];
        end
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (sel == 2'(i)) begin
                if (do_write) n_fill[i] = r_fill[i] + FW'(1);
                if (do_read)  n_fill[i] = r_fill[i] - FW'(1);
            end
        end
    end

    assign sum   = CW'(n_fill[0]) + CW'(n_fill[1]) + CW'(n_fill[2]);
    assign count = (sum > CNT_SAT) ? 6'(COUNT_MAX) : 6'(sum);

    // Ring pointer and fill updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_fill[i] <= n_fill[i];
                if (sel == 2'(i) && do_write) r_tail[i] <= ptr_next;
                if (sel == 2'(i) && do_read)  r_head[i] <= ptr_next;
            end
        end
    end

    // Result fields known at execute time
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_valid  <= do_read;
            r_level  <= do_read ? (sel + 2'd1) : LVL_NONE;
            r_status <= status;
            r_count  <= count;
        end
    end

    // Entry memory: level rings laid out one after another
    tspq_ram #(
        .WIDTH (WORD),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (do_read),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Result, age and tag straight from the registered read data
    assign o_result.entry_valid = r_valid;
    assign o_result.out_level   = r_level;
    assign o_result.out_age     = r_valid ? rdata[WORD-1 -: 8] : 8'd0;
    assign o_result.out_tag     = r_valid ? 32'(rdata[KEEP-1:0]) : 32'd0;
    assign o_result.status_code = r_status;
    assign o_result.total_count = r_count;

endmodule

`default_nettype wire

### design/three_level_stable_priority_queue.sv
// Top level of the three-level stable priority queue.
//
//  channel   handshake          payload            transfer when
//  request   start / busy       i_item  (t_in)     start && !busy at clock edge
//  result    o_done             o_result (t_out)   o_done high, one cycle
//
// Each operation runs in an execute state (pointer update and one memory
// access), then a present state (memory read data registered). A new request is
// taken during the present cycle, so the next operation starts while a result is shown.
// busy is high only in the execute cycle. Synchronous active-low reset
// empties all three levels at once; memory contents are not cleared.
// The receiver cannot stall; o_done lasts exactly one cycle per request.
`default_nettype none

module three_level_stable_priority_queue
    import tspq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out      o_result
);

    t_ctrl_cmd cmd;

    // Sequencer
    tspq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Rings, memory, result
    tspq_dpath #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

    assign o_done = cmd.done;

endmodule

`default_nettype wire

### design/tspq_checker.sv
// Port-level checks of the priority queue and their binding to the top level.
`default_nettype none

module tspq_checker
    import tspq_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire t_out o_result
);

    // An accepted transfer makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Every busy cycle is followed by a result
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("busy cycle not followed by result");

    // Results are never back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    // A returned entry carries ok status and a real level
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.entry_valid) |->
            (o_result.status_code == ST_OK && o_result.out_level != LVL_NONE))
        else $error("returned entry with bad status or level");

    // No entry means empty entry fields
    a_novalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.entry_valid) |->
            (o_result.out_level == LVL_NONE && o_result.out_age == 8'd0 &&
             o_result.out_tag == 32'd0))
        else $error("entry fields set without a returned entry");

endmodule

bind three_level_stable_priority_queue tspq_checker u_tspq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
